FILE: hdl/dds_pkg.sv
package dds_pkg;

	// Default geometry of the generator.
	localparam int unsigned TABLE_DEPTH_DEF = 1024;
	localparam int unsigned PHASE_BITS_DEF  = 32;
	localparam int unsigned SAMPLE_BITS_DEF = 12;

	// Fixed field widths of the stream and configuration ports.
	localparam int unsigned TI_W       = 10;
	localparam int unsigned TV_W       = 12;
	localparam int unsigned SPI_W      = 14;
	localparam int unsigned SMP_W      = 12;
	localparam int unsigned S_TDATA_W  = 24;
	localparam int unsigned M_TDATA_W  = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned AMP_W      = 3;

	localparam logic [SPI_W-1:0]      DAC_HEADER   = 14'h3000;
	localparam logic [CFG_DATA_W-1:0] TUNING_RESET = 32'd42949;
	localparam logic [AMP_W-1:0]      AMP_RESET    = 3'd4;
	localparam logic [AMP_W-1:0]      AMP_MAX      = 3'd5;

	// The sawtooth rises by 2^14 * amplitude / 21 over one full table sweep.
	localparam int unsigned SAW_SCALE_LOG2 = 14;
	localparam int unsigned SAW_DIVISOR    = 21;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TUNING = 2'd0,
		CFG_MODE   = 2'd1,
		CFG_AMP    = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		WAVE_SINE   = 2'd0,
		WAVE_SAW    = 2'd1,
		WAVE_SQUARE = 2'd2,
		WAVE_DC     = 2'd3
	} wave_mode_t;

	// Square wave high level: 2048 + floor(1897 * a / 5).
	function automatic logic [SMP_W-1:0] square_high(input logic [AMP_W-1:0] amp);
		logic [SMP_W-1:0] v;
		unique case (amp)
			3'd0:    v = 12'd2048;
			3'd1:    v = 12'd2427;
			3'd2:    v = 12'd2806;
			3'd3:    v = 12'd3186;
			3'd4:    v = 12'd3565;
			default: v = 12'd3945;
		endcase
		return v;
	endfunction

	// Square wave low level: 2048 - ceil(1897 * a / 5).
	function automatic logic [SMP_W-1:0] square_low(input logic [AMP_W-1:0] amp);
		logic [SMP_W-1:0] v;
		unique case (amp)
			3'd0:    v = 12'd2048;
			3'd1:    v = 12'd1668;
			3'd2:    v = 12'd1289;
			3'd3:    v = 12'd909;
			3'd4:    v = 12'd530;
			default: v = 12'd151;
		endcase
		return v;
	endfunction

	// DC level: floor(2048 * (5 - a) / 5).
	function automatic logic [SMP_W-1:0] dc_level(input logic [AMP_W-1:0] amp);
		logic [SMP_W-1:0] v;
		unique case (amp)
			3'd0:    v = 12'd2048;
			3'd1:    v = 12'd1638;
			3'd2:    v = 12'd1228;
			3'd3:    v = 12'd819;
			3'd4:    v = 12'd409;
			default: v = 12'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: hdl/dds_waveform_generator.sv
// A sample tick beat on s_* moves through the stages and the output register to m_*.
// Throughput: one beat per cycle, tick or table write, while no stall fills the stages;
// index multiply, sine memory read and sawtooth reciprocal multiply each own one stage.
// Table write beats pass through stage one only, are stored as they leave it, no output.
// Reset clears the phase accumulator, the pipeline and the registers to their defaults;
// the sine memory is not cleared and holds undefined data until entries are written.
module dds_waveform_generator #(
	parameter int unsigned TABLE_DEPTH = dds_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned PHASE_BITS  = dds_pkg::PHASE_BITS_DEF,
	parameter int unsigned SAMPLE_BITS = dds_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [9:0] table_index, [21:10] table_value, [23:22] zero
	input  logic [dds_pkg::S_TDATA_W-1:0]    s_tdata,
	// [0] cmd
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [13:0] spi_word, [15:14] zero
	output logic [dds_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dds_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dds_pkg::*;

	localparam int unsigned IDX_W     = $clog2(TABLE_DEPTH);
	localparam int unsigned IDXP_W    = PHASE_BITS + IDX_W + 1;
	localparam int unsigned X_W       = IDX_W + AMP_W;
	localparam int unsigned SAW_SHIFT = $clog2(5 * TABLE_DEPTH) + $clog2(21 * TABLE_DEPTH);
	localparam int unsigned SP_W      = SAW_SHIFT + SMP_W;
	localparam logic [63:0] SAW_DIV   = 64'(SAW_DIVISOR) * 64'(TABLE_DEPTH);
	// Rounded-up reciprocal; the shift is wide enough that the floor comes out exact.
	localparam logic [63:0] SAW_RECIP =
		((64'd1 << (SAW_SHIFT + SAW_SCALE_LOG2)) + SAW_DIV - 64'd1) / SAW_DIV;
	localparam logic [SMP_W-1:0]  SMP_MAX   = SMP_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [IDX_W-1:0]  HALF_IDX  = IDX_W'(TABLE_DEPTH / 2);

	function automatic logic [SMP_W-1:0] clamp_smp(input logic [SMP_W-1:0] v);
		return (v > SMP_MAX) ? SMP_MAX : v;
	endfunction

	// Configuration registers.
	logic [PHASE_BITS-1:0] tuning_q;
	wave_mode_t            wave_q;
	logic [AMP_W-1:0]      amp_q;

	// State and pipeline.
	logic [PHASE_BITS-1:0]  phase_acc_q;
	logic [PHASE_BITS-1:0]  phase_sum;
	logic [SAMPLE_BITS-1:0] sine_mem [TABLE_DEPTH];

	logic                   v_s1, v_s2, v_s3, v_s4, vo_q;
	logic                   ld1, ld2, ld3, ld4, ld_o;
	logic                   wr_s1;
	logic [TI_W-1:0]        wr_idx_s1;
	logic [TV_W-1:0]        wr_val_s1;
	logic [PHASE_BITS-1:0]  phase_s1;
	logic [IDX_W-1:0]       idx_s2;
	logic [SAMPLE_BITS-1:0] rd_s3, rd_s4;
	logic [X_W-1:0]         x_s3;
	logic                   upper_s3, upper_s4;
	logic [SMP_W-1:0]       saw_s4;
	logic [SPI_W-1:0]       spi_q;

	logic [IDXP_W-1:0]      idx_prod;
	logic [SP_W-1:0]        saw_prod;
	logic [SMP_W-1:0]       smp;

	logic [TI_W-1:0]        tbl_index;
	logic [TV_W-1:0]        tbl_value;
	logic                   in_beat, tick_beat, wr_in_range;

	assign tbl_index = s_tdata[TI_W-1:0];
	assign tbl_value = s_tdata[TI_W +: TV_W];

	assign cfg_ready = 1'b1;

	// Each stage takes a new beat when it is empty or its content moves on.
	assign ld_o     = !vo_q || m_tready;
	assign ld4      = !v_s4 || ld_o;
	assign ld3      = !v_s3 || ld4;
	assign ld2      = !v_s2 || ld3;
	assign ld1      = !v_s1 || ld2;
	assign s_tready = ld1;

	assign in_beat     = s_tvalid && s_tready;
	assign tick_beat   = in_beat && !s_tuser;
	assign wr_in_range = 32'(wr_idx_s1) < 32'(TABLE_DEPTH);

	assign phase_sum = phase_acc_q + tuning_q;
	assign idx_prod  = IDXP_W'(phase_s1) * IDXP_W'(TABLE_DEPTH);
	assign saw_prod  = SP_W'(x_s3) * SP_W'(SAW_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuning_q <= PHASE_BITS'(TUNING_RESET);
			wave_q   <= WAVE_SINE;
			amp_q    <= AMP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TUNING: tuning_q <= PHASE_BITS'(cfg_data);
				CFG_MODE:   wave_q   <= wave_mode_t'(cfg_data[1:0]);
				CFG_AMP:    amp_q    <= (cfg_data[AMP_W-1:0] > AMP_MAX) ?
				                        AMP_MAX : cfg_data[AMP_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			v_s1        <= 1'b0;
			wr_s1       <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			vo_q        <= 1'b0;
		end else begin
			if (tick_beat) begin
				phase_acc_q <= phase_sum;
			end
			if (ld1) begin
				v_s1  <= in_beat;
				wr_s1 <= s_tuser;
			end
			if (ld2) begin
				v_s2 <= v_s1 && !wr_s1;
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
			if (ld4) begin
				v_s4 <= v_s3;
			end
			if (ld_o) begin
				vo_q <= v_s4;
			end
		end
	end

	// Sine memory: a table write is stored as it leaves stage one and a tick reads as it
	// leaves stage two. Every older tick has read by then and every younger one reads
	// later; a read in the same cycle as a store belongs to an older tick and must see
	// the old contents, which the clocked read gives.
	always_ff @(posedge clk) begin
		if (v_s1 && wr_s1 && ld2 && wr_in_range) begin
			sine_mem[IDX_W'(wr_idx_s1)] <= SAMPLE_BITS'(wr_val_s1);
		end
		if (ld3) begin
			rd_s3 <= sine_mem[idx_s2];
		end
	end

	always_comb begin
		unique case (wave_q)
			WAVE_SINE:   smp = SMP_W'(rd_s4);
			WAVE_SAW:    smp = clamp_smp(saw_s4);
			WAVE_SQUARE: smp = clamp_smp(upper_s4 ? square_low(amp_q) : square_high(amp_q));
			WAVE_DC:     smp = clamp_smp(dc_level(amp_q));
			default:     smp = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			phase_s1  <= phase_sum;
			wr_idx_s1 <= tbl_index;
			wr_val_s1 <= tbl_value;
		end
		if (ld2) begin
			idx_s2 <= idx_prod[PHASE_BITS +: IDX_W];
		end
		if (ld3) begin
			x_s3     <= X_W'(idx_s2) * X_W'(amp_q);
			upper_s3 <= !(idx_s2 < HALF_IDX);
		end
		if (ld4) begin
			rd_s4    <= rd_s3;
			upper_s4 <= upper_s3;
			saw_s4   <= saw_prod[SAW_SHIFT +: SMP_W];
		end
		if (ld_o) begin
			spi_q <= DAC_HEADER | SPI_W'(smp);
		end
	end

	assign m_tvalid = vo_q;
	assign m_tdata  = M_TDATA_W'(spi_q);

	// A table write leaves the pipeline at stage one.
	a_write_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && wr_s1 && ld2) |=> !v_s2)
		else $error("table write beat went past stage one");

	// The phase only moves on a tick beat.
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_beat |=> $stable(phase_acc_q))
		else $error("phase accumulator moved without a tick");

	// Back-pressure reaches the input only when every stage is full and the sink stalls.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && vo_q && !m_tready))
		else $error("input stalled with a free stage");

	// Every output word carries the DAC header.
	a_header: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:12] == 2'b11))
		else $error("output word lacks the DAC header");

endmodule

FILE: dv/dds_waveform_generator_test.sv
`timescale 1ns / 1ps

module dds_waveform_generator_test;
	import dds_pkg::*;

	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned SEG_ITEMS    = 30;
	localparam int unsigned LOAD_ITEMS   = 32;
	localparam int unsigned HALF_TABLE   = TABLE_DEPTH_DEF / 2;
	localparam int unsigned SAMPLE_TOP   = (1 << SMP_W) - 1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Shadow copy of the generator state.
	logic [31:0]      shadow_phase;
	logic [31:0]      shadow_tuning;
	wave_mode_t       shadow_mode;
	logic [AMP_W-1:0] shadow_amp;
	logic [SMP_W-1:0] shadow_sine [TABLE_DEPTH_DEF];
	bit               shadow_written [TABLE_DEPTH_DEF];
	logic [SPI_W-1:0] dac_words_due [$];

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int hold_off_cycles = 0;
	int idle_cycles = 0;
	int ticks_sent = 0;
	int writes_sent = 0;
	int reg_writes = 0;
	int words_checked = 0;
	int mismatches = 0;

	dds_waveform_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [9:0] table_index, [21:10] table_value, [23:22] zero
		.s_tuser   (s_tuser),   // [0] cmd
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [13:0] spi_word, [15:14] zero
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [SMP_W-1:0] wave_sample(input logic [9:0] idx);
		int unsigned a;
		int unsigned v;
		a = 32'(shadow_amp);
		case (shadow_mode)
			WAVE_SINE:   v = 32'(shadow_sine[idx]);
			WAVE_SAW:    v = (int'(idx) * 16 * a) / 21;
			WAVE_SQUARE: v = (idx < HALF_TABLE) ? 2048 + (1897 * a) / 5 :
			                                      2048 - (1897 * a + 4) / 5;
			default:     v = (2048 * (5 - a)) / 5;
		endcase
		if (v > SAMPLE_TOP)
			v = SAMPLE_TOP;
		return v[SMP_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		if (mismatches < 20)
			$display("%0t mismatch, %s: got %h, want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// One beat on the input stream; the shadow state follows it once it is taken.
	task automatic send_item(input logic is_write, input logic [TI_W-1:0] index,
	                         input logic [TV_W-1:0] value);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= is_write;
		s_tdata  <= {2'b00, value, index};
		do @(posedge clk); while (!s_tready);
		if (is_write) begin
			shadow_sine[index] = value;
			shadow_written[index] = 1'b1;
			writes_sent++;
		end else begin
			shadow_phase = shadow_phase + shadow_tuning;
			dac_words_due.push_back(DAC_HEADER | SPI_W'(wave_sample(shadow_phase[31:22])));
			ticks_sent++;
		end
	endtask

	// In sine mode a tick that would read an empty entry has that entry written first.
	task automatic send_tick();
		logic [31:0] next_phase;
		next_phase = shadow_phase + shadow_tuning;
		if (shadow_mode == WAVE_SINE && !shadow_written[next_phase[31:22]])
			send_item(1'b1, next_phase[31:22], TV_W'($urandom));
		send_item(1'b0, '0, '0);
	endtask

	task automatic idle_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (dac_words_due.size() != 0)
			@(posedge clk);
		// Table writes leave no word behind, so give the pipeline time to settle.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			CFG_TUNING: shadow_tuning = data;
			CFG_MODE:   shadow_mode = wave_mode_t'(data[1:0]);
			CFG_AMP:    shadow_amp = (data[2:0] > AMP_MAX) ? AMP_MAX : data[2:0];
			default:    ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] tuning, input logic [31:0] mode,
	                          input logic [31:0] amp);
		idle_until_drained();
		write_reg(CFG_TUNING, tuning);
		write_reg(CFG_MODE, mode);
		write_reg(CFG_AMP, amp);
	endtask

	function automatic logic [31:0] pick_tuning();
		logic [31:0] t;
		case ($urandom_range(5))
			0:       t = $urandom;
			1:       t = $urandom_range(1, 65535);
			2:       t = 32'hFFFF_FFFF - $urandom_range(0, 3);
			3:       t = 32'd1 << $urandom_range(31);
			4:       t = 32'd0;
			default: t = (32'($urandom_range(0, 63)) << 22) | $urandom_range(0, 1023);
		endcase
		return t;
	endfunction

	// A spread of sine entries, including the smallest and the largest sample.
	task automatic test_table_load();
		for (int i = 0; i < LOAD_ITEMS; i++) begin
			if (i == 0)
				send_item(1'b1, '0, '0);
			else if (i == LOAD_ITEMS - 1)
				send_item(1'b1, '1, '1);
			else
				send_item(1'b1, TI_W'($urandom), TV_W'($urandom));
		end
	endtask

	task automatic test_phase_hold();
		logic [TI_W-1:0] idx;
		send_tick();
		send_tick();
		set_config(32'd0, WAVE_SINE, 32'd4);
		write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
		send_tick();
		// With a zero tuning word the next tick reads the entry just replaced.
		idx = shadow_phase[31:22];
		send_item(1'b1, idx, 12'hA5C);
		send_tick();
		set_config(32'hFFC0_0000, WAVE_SINE, 32'd4);
		send_tick();
		set_config(32'hFFFF_FFFF, WAVE_SINE, 32'd4);
		send_tick();
	endtask

	task automatic test_wave_levels();
		wave_mode_t shapes [3] = '{WAVE_SAW, WAVE_SQUARE, WAVE_DC};
		int unsigned amps [3] = '{0, 5, 7};
		foreach (shapes[m])
			foreach (amps[k]) begin
				set_config(32'h8000_0000, shapes[m], amps[k]);
				send_tick();
				send_tick();
			end
	endtask

	task automatic test_output_stall();
		set_config(pick_tuning(), WAVE_SINE, 32'd5);
		src_idle_pct = 0;
		hold_off_cycles = HOLD_CYCLES;
		repeat (40) send_tick();
	endtask

	task automatic run_random_phase(input int src_pct, input int sink_pct, input int segments);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		repeat (segments) begin
			set_config(pick_tuning(), $urandom, $urandom);
			repeat (SEG_ITEMS) begin
				if ($urandom_range(99) < 85)
					send_tick();
				else
					send_item(1'b1, TI_W'($urandom), TV_W'($urandom));
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			m_tready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin : check_words
		logic [SPI_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (dac_words_due.size() == 0) begin
				report_mismatch("word with none due", 32'(m_tdata), '0);
			end else begin
				want = dac_words_due.pop_front();
				words_checked++;
				if (m_tdata[SPI_W-1:0] !== want)
					report_mismatch("spi_word", 32'(m_tdata[SPI_W-1:0]), 32'(want));
				if (m_tdata[M_TDATA_W-1:SPI_W] !== '0)
					report_mismatch("tdata padding", 32'(m_tdata), '0);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("no beat moved for %0d cycles, %0d words still due",
			         idle_cycles, dac_words_due.size());
			$display("FAIL dds_waveform_generator");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		shadow_phase = '0;
		shadow_tuning = TUNING_RESET;
		shadow_mode = WAVE_SINE;
		shadow_amp = AMP_RESET;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_table_load();
		src_idle_pct = 11;
		sink_idle_pct = 72;
		test_phase_hold();
		test_wave_levels();
		test_output_stall();
		run_random_phase(11, 72, 3);
		run_random_phase(72, 11, 3);
		run_random_phase(0, 0, 3);
		idle_until_drained();

		$display("Sent %0d sample ticks and %0d table writes across %0d register writes.",
		         ticks_sent, writes_sent, reg_writes);
		$display("Checked %0d DAC words: all four shapes, both idle mixes, a long hold-off.",
		         words_checked);
		if (mismatches == 0)
			$display("PASS dds_waveform_generator");
		else
			$display("FAIL dds_waveform_generator");
		$finish;
	end

endmodule
